/* hw/rtl/crc16_response_frame_checker_defines.svh */
// Assertion macros shared by the RTL of the framed CRC-16 response checker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef CRC16_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define CRC16_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define CRFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define CRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/crfc_pkg.sv */
// Types, codes and the CRC byte update for the framed CRC-16 response checker.
// No dependencies.
package crfc_pkg;

  localparam logic [15:0] CrcPoly     = 16'h8005;
  localparam logic [7:0]  StWake      = 8'h11;
  localparam logic [7:0]  StWdExpired = 8'hEE;
  localparam logic [7:0]  StCrcError  = 8'hFF;
  localparam logic [7:0]  MaxCount    = 8'd7;
  localparam logic [7:0]  MinCount    = 8'd3;
  localparam logic [2:0]  StatusCount = 3'd4;
  localparam logic [2:0]  DataCount   = 3'd7;

  typedef enum logic [2:0] {
    VERDICT_DATA_OK   = 3'd0,
    VERDICT_WAKE      = 3'd1,
    VERDICT_WD_EXP    = 3'd2,
    VERDICT_DEV_CRC   = 3'd3,
    VERDICT_STATUS    = 3'd4,
    VERDICT_BAD_LEN   = 3'd5,
    VERDICT_BAD_CRC   = 3'd6,
    VERDICT_UNKNOWN   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] data_word;
    logic [7:0]  status_code;
  } out_item_t;

  // Feed one byte, LSB first, into the non-reflected CRC register
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (b[i] != c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc16_response_frame_checker.sv */
// Framed CRC-16 response checker: one byte per cycle in, one verdict per frame out.
// A frame's verdict is registered in the output register, or in the skid register while
// the output is stalled. A byte is accepted every cycle while the two-entry result buffer
// (output register plus skid register) has room, so the sustained rate is one byte per
// clock. The CRC byte update is an unrolled XOR network in the same cycle as the byte.
// Uses crfc_pkg and crc16_response_frame_checker_defines.svh.
`include "crc16_response_frame_checker_defines.svh"

module crc16_response_frame_checker
  import crfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic        in_frame_q, in_frame_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [2:0]  frame_count_q, frame_count_d;
  logic [15:0] crc_q, crc_d;
  logic [31:0] payload_q, payload_d;
  logic [7:0]  crc_low_q, crc_low_d;

  logic        out_valid_q;
  out_item_t   out_q;
  logic        skid_valid_q;
  out_item_t   skid_q;

  logic        accept;
  logic        res_valid;
  out_item_t   res;
  logic [3:0]  idx_plus2;
  logic [15:0] crc_next;
  logic [7:0]  st_byte;

  // Stall the input only when both result slots are taken
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_plus2 = {1'b0, byte_index_q} + 4'd2;
  assign crc_next  = crc_feed(crc_q, in_data_i.rx_byte);
  assign st_byte   = payload_q[7:0];

  // Frame tracking and verdict for the byte on the input
  always_comb begin
    in_frame_d    = in_frame_q;
    byte_index_d  = byte_index_q;
    frame_count_d = frame_count_q;
    crc_d         = crc_q;
    payload_d     = payload_q;
    crc_low_d     = crc_low_q;
    res_valid     = 1'b0;
    res           = '0;
    if (accept) begin
      priority if (in_data_i.frame_start) begin
        crc_d     = '0;
        payload_d = '0;
        crc_low_d = '0;
        if (in_data_i.rx_byte > MaxCount || in_data_i.rx_byte < MinCount) begin
          in_frame_d    = 1'b0;
          byte_index_d  = '0;
          frame_count_d = '0;
          res_valid     = 1'b1;
          res.verdict   = VERDICT_BAD_LEN;
        end else begin
          frame_count_d = in_data_i.rx_byte[2:0];
          crc_d         = crc_feed(16'h0000, in_data_i.rx_byte);
          byte_index_d  = 3'd1;
          in_frame_d    = 1'b1;
        end
      end else if (!in_frame_q) begin
        // drop stray byte
      end else if (idx_plus2 < {1'b0, frame_count_q}) begin
        crc_d = crc_next;
        unique case (byte_index_q)
          3'd1:    payload_d[7:0]   = in_data_i.rx_byte;
          3'd2:    payload_d[15:8]  = in_data_i.rx_byte;
          3'd3:    payload_d[23:16] = in_data_i.rx_byte;
          3'd4:    payload_d[31:24] = in_data_i.rx_byte;
          default: payload_d        = payload_q;
        endcase
        byte_index_d = byte_index_q + 3'd1;
      end else if (idx_plus2 == {1'b0, frame_count_q}) begin
        crc_low_d    = in_data_i.rx_byte;
        byte_index_d = byte_index_q + 3'd1;
      end else begin
        // CRC high byte closes the frame
        in_frame_d   = 1'b0;
        byte_index_d = '0;
        res_valid    = 1'b1;
        priority if (crc_low_q != crc_q[7:0] || in_data_i.rx_byte != crc_q[15:8]) begin
          res.verdict = VERDICT_BAD_CRC;
        end else if (frame_count_q == StatusCount) begin
          res.status_code = st_byte;
          priority if (st_byte == StWake)      res.verdict = VERDICT_WAKE;
          else if (st_byte == StWdExpired)     res.verdict = VERDICT_WD_EXP;
          else if (st_byte == StCrcError)      res.verdict = VERDICT_DEV_CRC;
          else                                 res.verdict = VERDICT_STATUS;
        end else if (frame_count_q == DataCount) begin
          res.verdict   = VERDICT_DATA_OK;
          res.data_word = payload_q;
        end else begin
          res.verdict = VERDICT_UNKNOWN;
        end
      end
    end
  end

  // Hold frame control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      byte_index_q  <= '0;
      frame_count_q <= '0;
      crc_q         <= '0;
      payload_q     <= '0;
      crc_low_q     <= '0;
    end else begin
      in_frame_q    <= in_frame_d;
      byte_index_q  <= byte_index_d;
      frame_count_q <= frame_count_d;
      crc_q         <= crc_d;
      payload_q     <= payload_d;
      crc_low_q     <= crc_low_d;
    end
  end

  // Output register and skid register for result transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= res_valid;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (res_valid) begin
      out_q <= res;
    end
  end

  `CRFC_ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q,
                    "skid holds a result while the output register is empty")
  `CRFC_ASSERT_SAME(a_index_in_range, in_frame_q,
                    (byte_index_q != 3'd0) && (byte_index_q < frame_count_q),
                    "byte index outside the open frame")
  `CRFC_ASSERT_SAME(a_data_only_ok,
                    out_valid_q && (out_q.verdict != VERDICT_DATA_OK),
                    out_q.data_word == 32'h0,
                    "data word set on a non-data verdict")
  `CRFC_ASSERT_NEXT(a_drain,
                    out_valid_q && !out_stall_i && !skid_valid_q && !res_valid,
                    !out_valid_q,
                    "result shown again after it was taken")

endmodule

/* test/tb.sv */
// Self-checking testbench for the framed CRC-16 response checker.
// Drives response bytes through the valid/stall input channel, predicts each verdict
// in-bench, and checks results taken from the output channel. Needs crfc_pkg.
`timescale 1ns / 1ps

module tb;
  import crfc_pkg::*;

  // Clock, reset and channel signals
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predictor state for the response currently being received
  logic        resp_open;
  logic [2:0]  resp_idx;
  logic [2:0]  resp_count;
  logic [15:0] resp_crc;
  logic [31:0] resp_word;
  logic [7:0]  resp_crc_lo;

  out_item_t   pending_verdicts[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  logic [7:0]  frame_buf[4];

  // Idle controls for both sides
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int          hold_left = 0;

  always #4 clk_i = ~clk_i;

  crc16_response_frame_checker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // One CRC-16 byte update: LSB of the byte first, register shifts left
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[15] ^ b[k];
      r = r << 1;
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Advance the predictor by one accepted byte; queue the verdict it causes
  task automatic predict_response_byte(input in_item_t it);
    out_item_t res;
    int        idx;
    int        cnt;
    bit        done;
    res  = '0;
    done = 1'b0;
    if (it.frame_start) begin
      resp_crc    = '0;
      resp_word   = '0;
      resp_crc_lo = '0;
      if (it.rx_byte > MaxCount || it.rx_byte < MinCount) begin
        resp_open   = 1'b0;
        resp_idx    = '0;
        resp_count  = '0;
        res.verdict = VERDICT_BAD_LEN;
        done        = 1'b1;
      end else begin
        resp_count = it.rx_byte[2:0];
        resp_crc   = crc_step(16'h0000, it.rx_byte);
        resp_idx   = 3'd1;
        resp_open  = 1'b1;
      end
    end else if (resp_open) begin
      idx = resp_idx;
      cnt = resp_count;
      if (idx + 2 < cnt) begin
        resp_crc = crc_step(resp_crc, it.rx_byte);
        if (idx >= 1 && idx <= 4) begin
          resp_word = resp_word | (32'(it.rx_byte) << (8 * (idx - 1)));
        end
        resp_idx = resp_idx + 3'd1;
      end else if (idx + 2 == cnt) begin
        resp_crc_lo = it.rx_byte;
        resp_idx    = resp_idx + 3'd1;
      end else begin
        // Last byte: CRC high, then classify
        resp_open = 1'b0;
        resp_idx  = '0;
        done      = 1'b1;
        if (resp_crc_lo != resp_crc[7:0] || it.rx_byte != resp_crc[15:8]) begin
          res.verdict = VERDICT_BAD_CRC;
        end else if (cnt == StatusCount) begin
          res.status_code = resp_word[7:0];
          case (resp_word[7:0])
            StWake:      res.verdict = VERDICT_WAKE;
            StWdExpired: res.verdict = VERDICT_WD_EXP;
            StCrcError:  res.verdict = VERDICT_DEV_CRC;
            default:     res.verdict = VERDICT_STATUS;
          endcase
        end else if (cnt == DataCount) begin
          res.verdict   = VERDICT_DATA_OK;
          res.data_word = resp_word;
        end else begin
          res.verdict = VERDICT_UNKNOWN;
        end
      end
    end
    if (done) begin
      pending_verdicts.push_back(res);
    end
  endtask

  // Offer one byte, hold it until accepted, then maybe leave a gap.
  // Called at a rising edge; returns at a rising edge.
  task automatic send_item(input logic [7:0] b, input logic start);
    in_item_t it;
    it.rx_byte     = b;
    it.frame_start = start;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    if (start || resp_open) begin
      bytes_sent++;
    end
    predict_response_byte(it);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  // Send count byte, n payload bytes from frame_buf and the CRC, optionally damaged
  task automatic send_frame(input int n, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  cnt;
    cnt = 8'(n + 3);
    crc = crc_step(16'h0000, cnt);
    send_item(cnt, 1'b1);
    for (int i = 0; i < n; i++) begin
      crc = crc_step(crc, frame_buf[i]);
      send_item(frame_buf[i], 1'b0);
    end
    if (corrupt) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_item(crc[7:0], 1'b0);
    send_item(crc[15:8], 1'b0);
  endtask

  // Random valid count and content, CRC sometimes damaged if allowed; status bytes favor the named codes
  task automatic send_random_frame(input bit allow_corrupt);
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < 4; i++) begin
      frame_buf[i] = 8'($urandom_range(0, 255));
    end
    if (n == 1) begin
      case ($urandom_range(0, 4))
        0: frame_buf[0] = StWake;
        1: frame_buf[0] = StWdExpired;
        2: frame_buf[0] = StCrcError;
        default: ;
      endcase
    end
    send_frame(n, allow_corrupt && $urandom_range(0, 9) == 0);
  endtask

  // Broken traffic: stray bytes, random starts, truncated frames, full frames of random bytes
  task automatic send_noise();
    int k;
    case ($urandom_range(0, 3))
      0: send_item(8'($urandom_range(0, 255)), 1'b0);
      1: send_item(8'($urandom_range(0, 255)), 1'b1);
      2: begin
        k = $urandom_range(3, 7);
        send_item(8'(k), 1'b1);
        repeat ($urandom_range(0, k - 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        k = $urandom_range(3, 7);
        send_item(8'(k), 1'b1);
        repeat (k - 1) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // Compare each taken result with the oldest expectation
  task automatic check_result(input out_item_t act);
    out_item_t exp_res;
    if (pending_verdicts.size() == 0) begin
      mismatch_count++;
      $display("%0t: result expected none actual verdict %0d data %h status %h",
               $time, act.verdict, act.data_word, act.status_code);
      return;
    end
    exp_res = pending_verdicts.pop_front();
    if (act.verdict !== exp_res.verdict) begin
      mismatch_count++;
      $display("%0t: verdict expected %0d actual %0d", $time, exp_res.verdict,
               act.verdict);
    end
    if (act.data_word !== exp_res.data_word) begin
      mismatch_count++;
      $display("%0t: data_word expected %h actual %h", $time, exp_res.data_word,
               act.data_word);
    end
    if (act.status_code !== exp_res.status_code) begin
      mismatch_count++;
      $display("%0t: status_code expected %h actual %h", $time, exp_res.status_code,
               act.status_code);
    end
  endtask

  // Sample the output channel mid-cycle; the transaction completes at the next edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        check_result(out_data);
      end
    end
  end

  // Drive the receiver stall: long holds on request, random bursts otherwise
  initial begin
    logic stall_next;
    forever begin
      @(posedge clk_i);
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        hold_left  = idle_len() - 1;
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  // Fixed bytes: a stray byte, out-of-range counts, the three named status codes and one data frame
  task automatic test_directed_cases();
    send_item(8'hA5, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h02, 1'b1);
    send_item(8'h08, 1'b1);
    send_item(8'hFF, 1'b1);
    frame_buf[0] = StWake;
    send_frame(1, 1'b0);
    frame_buf[0] = StWdExpired;
    send_frame(1, 1'b0);
    frame_buf[0] = StCrcError;
    send_frame(1, 1'b0);
    frame_buf[0] = 8'hFF;
    frame_buf[1] = 8'h00;
    frame_buf[2] = 8'h80;
    frame_buf[3] = 8'h01;
    send_frame(4, 1'b0);
  endtask

  // Mostly good frames with some noise, first with idling on both sides, then without
  task automatic test_random_traffic();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (bytes_sent < 1000) begin
      if ($urandom_range(0, 9) < 8) send_random_frame(1'b1);
      else send_noise();
    end
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (bytes_sent < 1300) begin
      if ($urandom_range(0, 9) < 8) send_random_frame(1'b1);
      else send_noise();
    end
  endtask

  // Hold off the receiver for a long stretch while frames keep coming
  task automatic test_receiver_hold();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  = 400;
    repeat (30) send_random_frame(1'b0);
  endtask

  // Noise-heavy traffic: restarts inside frames, stray bytes, bad counts
  task automatic test_noise_and_restarts();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (bytes_sent < 1900) begin
      if ($urandom_range(0, 1) == 0) send_random_frame(1'b1);
      else send_noise();
    end
  endtask

  // Hard limit on the run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    resp_open   = 1'b0;
    resp_idx    = '0;
    resp_count  = '0;
    resp_crc    = '0;
    resp_word   = '0;
    resp_crc_lo = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic();
    test_receiver_hold();
    test_noise_and_restarts();

    // Drain: stop offering, wait for every verdict, then let the clock run on before the final check
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
